FILE: hw/rtl/bbs_pkg.sv
// Shared types and constants of the buzzer beep sequencer.
// Used by bbs_step and buzzer_beep_sequencer; depends on nothing.
package bbs_pkg;

  localparam logic [2:0] ACT_TICK     = 3'd0;
  localparam logic [2:0] ACT_CLICK    = 3'd1;
  localparam logic [2:0] ACT_ALARM    = 3'd2;
  localparam logic [2:0] ACT_POWER_ON = 3'd3;
  localparam logic [2:0] ACT_CUSTOM   = 3'd4;

  localparam logic [15:0] TONE_HZ     = 16'd2000;
  localparam logic [7:0]  TONE_VOL    = 8'd50;
  localparam logic [15:0] CLICK_ON_MS = 16'd48;
  localparam logic [15:0] ALARM_MS    = 16'd100;
  localparam logic [15:0] POWER_ON_MS = 16'd300;

  // Register index on the configuration port.
  localparam logic REG_MUTE          = 1'b0;
  localparam logic REG_ALARM_REPEATS = 1'b1;
  localparam logic [7:0] ALARM_REPEATS_RESET = 8'd3;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] tone_freq;
    logic [7:0]  tone_volume;
    logic [15:0] on_time;
    logic [15:0] off_time;
    logic [7:0]  repeat_count;
  } req_item_t;

  typedef struct packed {
    logic        tone_enable;
    logic [15:0] out_freq;
    logic [7:0]  out_volume;
    logic [2:0]  queued_clicks;
    logic        busy_res;
  } rsp_item_t;

  typedef struct packed {
    logic [15:0] seq_freq;
    logic [7:0]  seq_volume;
    logic [15:0] seq_on_time;
    logic [15:0] seq_off_time;
    logic [15:0] phase_timer;
    logic [7:0]  tones_left;
    logic        tone_phase_on;
  } seq_state_t;

  typedef struct packed {
    logic       mute;
    logic [7:0] alarm_repeats;
  } cfg_t;

endpackage

FILE: hw/rtl/bbs_step.sv
// Next-state logic of the buzzer beep sequencer for one item.
// Depends on bbs_pkg; instantiated by buzzer_beep_sequencer.
module bbs_step #(
  parameter int QUEUE_DEPTH = 6,
  parameter int QW = 3
) (
  input  bbs_pkg::req_item_t  item,
  input  bbs_pkg::cfg_t       cfg,
  input  bbs_pkg::seq_state_t state,
  input  logic [QW-1:0]       queue,
  output bbs_pkg::seq_state_t state_next,
  output logic [QW-1:0]       queue_next
);

  bbs_pkg::seq_state_t click_seq;
  bbs_pkg::seq_state_t base;
  logic                run;

  always_comb begin
    click_seq = '{seq_freq: bbs_pkg::TONE_HZ, seq_volume: bbs_pkg::TONE_VOL,
                  seq_on_time: bbs_pkg::CLICK_ON_MS, seq_off_time: 16'd0,
                  phase_timer: bbs_pkg::CLICK_ON_MS, tones_left: 8'd1,
                  tone_phase_on: 1'b1};
  end

  always_comb begin
    state_next = state;
    queue_next = queue;
    base       = state;
    run        = 1'b1;
    case (item.action)
      bbs_pkg::ACT_TICK: begin
        // An idle sequencer pulls one queued click before counting.
        if (state.tones_left == 8'd0) begin
          if (queue == '0 || cfg.mute) begin
            run = 1'b0;
          end else begin
            queue_next = queue - QW'(1);
            base       = click_seq;
          end
        end
        if (run) begin
          state_next = base;
          if (base.phase_timer != 16'd0) begin
            state_next.phase_timer = base.phase_timer - 16'd1;
          end else if (base.tone_phase_on) begin
            state_next.tone_phase_on = 1'b0;
            state_next.phase_timer   = base.seq_off_time;
            if (base.seq_off_time == 16'd0) begin
              state_next.tones_left = 8'd0;
            end
          end else begin
            state_next.tones_left = base.tones_left - 8'd1;
            if (base.tones_left != 8'd1) begin
              state_next.tone_phase_on = 1'b1;
              state_next.phase_timer   = base.seq_on_time;
            end
          end
        end
      end
      bbs_pkg::ACT_CLICK: begin
        if (!cfg.mute) begin
          if (state.tones_left == 8'd0 && queue == '0) begin
            state_next = click_seq;
          end else if (queue < QW'(QUEUE_DEPTH)) begin
            queue_next = queue + QW'(1);
          end
        end
      end
      bbs_pkg::ACT_ALARM: begin
        if (!cfg.mute) begin
          state_next = '{seq_freq: bbs_pkg::TONE_HZ, seq_volume: bbs_pkg::TONE_VOL,
                         seq_on_time: bbs_pkg::ALARM_MS, seq_off_time: bbs_pkg::ALARM_MS,
                         phase_timer: bbs_pkg::ALARM_MS, tones_left: cfg.alarm_repeats,
                         tone_phase_on: 1'b1};
        end
      end
      bbs_pkg::ACT_POWER_ON: begin
        if (!cfg.mute) begin
          state_next = '{seq_freq: bbs_pkg::TONE_HZ, seq_volume: bbs_pkg::TONE_VOL,
                         seq_on_time: bbs_pkg::POWER_ON_MS, seq_off_time: 16'd0,
                         phase_timer: bbs_pkg::POWER_ON_MS, tones_left: 8'd1,
                         tone_phase_on: 1'b1};
        end
      end
      bbs_pkg::ACT_CUSTOM: begin
        if (!cfg.mute) begin
          state_next = '{seq_freq: item.tone_freq, seq_volume: item.tone_volume,
                         seq_on_time: item.on_time, seq_off_time: item.off_time,
                         phase_timer: item.on_time, tones_left: item.repeat_count,
                         tone_phase_on: 1'b1};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: hw/rtl/buzzer_beep_sequencer.sv
// Top level of the buzzer beep sequencer: request register, sequence state,
// result register and APB configuration registers. Depends on bbs_pkg, bbs_step.
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_ready   bbs_pkg::req_item_t
//   rsp       out        rsp_valid/rsp_ready   bbs_pkg::rsp_item_t
//   apb       in/out     psel/penable/pready   paddr, pwdata, prdata
//
// An accepted item is held in the request register; from there its result goes
// through the step logic into the result register, which holds it until it is
// taken. A new item is taken every cycle while the result is not stalled; the
// state update in bbs_step is combinational, which is what lets that rate hold.
// A stalled result holds the result register and the request register, and
// req_ready drops only when both are full.
// Reset is synchronous and clears all sequence state, the queue, mute and
// sets alarm_repeats to three.
module buzzer_beep_sequencer #(
  parameter int QUEUE_DEPTH = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  bbs_pkg::req_item_t  req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output bbs_pkg::rsp_item_t  rsp,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int QW = $clog2(QUEUE_DEPTH + 1);

  bbs_pkg::cfg_t       cfg;
  bbs_pkg::req_item_t  item;
  logic                item_valid;
  logic                step_fire;
  bbs_pkg::seq_state_t state;
  bbs_pkg::seq_state_t state_next;
  logic [QW-1:0]       queue;
  logic [QW-1:0]       queue_next;

  // The step fires when a held item can move into a free result register.
  assign step_fire = item_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !item_valid || step_fire;

  // Request register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req_ready) begin
      item_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      item <= req;
    end
  end

  bbs_step #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .QW(QW)
  ) u_step (
    .item(item),
    .cfg(cfg),
    .state(state),
    .queue(queue),
    .state_next(state_next),
    .queue_next(queue_next)
  );

  // Sequence state advances once for each item, in order.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
      queue <= '0;
    end else if (step_fire) begin
      state <= state_next;
      queue <= queue_next;
    end
  end

  // Result register shows the state after the item.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (step_fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      rsp.tone_enable   <= state_next.tone_phase_on;
      rsp.out_freq      <= state_next.seq_freq;
      rsp.out_volume    <= state_next.seq_volume;
      rsp.queued_clicks <= 3'(queue_next);
      rsp.busy_res      <= (state_next.tones_left != 8'd0);
    end
  end

  // Configuration registers; the address is decoded on bit 2 alone.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mute          <= 1'b0;
      cfg.alarm_repeats <= bbs_pkg::ALARM_REPEATS_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        bbs_pkg::REG_MUTE:          cfg.mute <= pwdata[0];
        bbs_pkg::REG_ALARM_REPEATS: cfg.alarm_repeats <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      bbs_pkg::REG_MUTE:          prdata = {31'd0, cfg.mute};
      bbs_pkg::REG_ALARM_REPEATS: prdata = {24'd0, cfg.alarm_repeats};
      default:                    prdata = '0;
    endcase
  end

  // The click count never passes its saturation limit.
  assert property (@(posedge clk) disable iff (rst) queue <= QW'(QUEUE_DEPTH))
    else $error("click queue above its depth");

  // Sequence state moves only when an item is stepped.
  assert property (@(posedge clk) disable iff (rst)
    !step_fire |=> $stable(state) && $stable(queue))
    else $error("sequence state changed without an item");

  // A held item that cannot step stays in the request register unchanged.
  assert property (@(posedge clk) disable iff (rst)
    item_valid && !step_fire |=> item_valid && $stable(item))
    else $error("held item lost or changed");

endmodule
